[src/bhpq_pkg.sv]
`default_nettype none
package bhpq_pkg;
  localparam int DEPTH_DEF    = 1024;
  localparam int KEY_BITS_DEF = 48;
  localparam int TAG_BITS_DEF = 16;

  localparam int KEY_W   = 48;
  localparam int TAG_W   = 16;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 11;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd4;

  localparam logic REG_ORDER_MAX = 1'b0;
endpackage
`default_nettype wire

[src/bhpq_in_if.sv]
`default_nettype none
interface bhpq_in_if;
  logic                                valid;
  logic                                ready;
  logic [bhpq_pkg::CMD_W-1:0]          command;
  logic signed [bhpq_pkg::KEY_W-1:0]   key;
  logic [bhpq_pkg::TAG_W-1:0]          tag;
  modport source (output valid, command, key, tag, input ready);
  modport sink   (input valid, command, key, tag, output ready);
endinterface
`default_nettype wire

[src/bhpq_out_if.sv]
`default_nettype none
interface bhpq_out_if;
  logic                                valid;
  logic                                ready;
  logic [bhpq_pkg::STAT_W-1:0]         status;
  logic signed [bhpq_pkg::KEY_W-1:0]   out_key;
  logic [bhpq_pkg::TAG_W-1:0]          out_tag;
  logic                                top_valid;
  logic [bhpq_pkg::COUNT_W-1:0]        count;
  modport source (output valid, status, out_key, out_tag, top_valid, count, input ready);
  modport sink   (input valid, status, out_key, out_tag, top_valid, count, output ready);
endinterface
`default_nettype wire

[src/bhpq_ram.sv]
`default_nettype none
module bhpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

[src/binary_heap_priority_queue.sv]
`default_nettype none
// channel   dir  handshake       payload
// in_ch     in   valid/ready     command, key, tag
// out_ch    out  valid/ready     status, out_key, out_tag, top_valid, count
// cfg_*     in   apb, pready=1   order_max at byte address 0
//
// one request at a time; every ram read goes through a registered read port
// insert: a tag scan over the stored entries, then a sift up the heap levels, then the top read
// extract: a sift down the heap levels; erase: a tag scan, then a sift up or down
// an order_max change rebuilds the heap by sifting down each of the count/2 inner nodes
// reset clears control state and count, order back to max-first; a pending result blocks in
module binary_heap_priority_queue #(
  parameter int DEPTH    = bhpq_pkg::DEPTH_DEF,
  parameter int KEY_BITS = bhpq_pkg::KEY_BITS_DEF,
  parameter int TAG_BITS = bhpq_pkg::TAG_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  bhpq_in_if.sink                      in_ch,
  bhpq_out_if.source                   out_ch,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire [bhpq_pkg::PADDR_W-1:0]  cfg_paddr,
  input  wire [bhpq_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [bhpq_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = KEY_BITS + TAG_BITS;
  localparam logic [KEY_BITS-1:0] KSIGN = {1'b1, {(KEY_BITS-1){1'b0}}};

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SC_RD  = 4'd1;
  localparam logic [3:0] S_SC_CK  = 4'd2;
  localparam logic [3:0] S_EX_RD  = 4'd3;
  localparam logic [3:0] S_EX_CK  = 4'd4;
  localparam logic [3:0] S_LA_RD  = 4'd5;
  localparam logic [3:0] S_LA_CK  = 4'd6;
  localparam logic [3:0] S_UP_RD  = 4'd7;
  localparam logic [3:0] S_UP_CK  = 4'd8;
  localparam logic [3:0] S_DL_RD  = 4'd9;
  localparam logic [3:0] S_DL_CK  = 4'd10;
  localparam logic [3:0] S_DR_RD  = 4'd11;
  localparam logic [3:0] S_DR_CK  = 4'd12;
  localparam logic [3:0] S_DN_DEC = 4'd13;
  localparam logic [3:0] S_NEXT   = 4'd14;
  localparam logic [3:0] S_TOP    = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic order_r, order_nxt;
  logic [bhpq_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0] kin_r, kin_nxt;
  logic [TAG_BITS-1:0] tin_r, tin_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [AW-1:0] chi_r, chi_nxt;
  logic [EW-1:0] mv_r, mv_nxt;
  logic [EW-1:0] ch_r, ch_nxt;
  logic ud_r, ud_nxt;
  logic reb_r, reb_nxt;
  logic have_r, have_nxt;
  logic pend_r, pend_nxt;
  logic [bhpq_pkg::STAT_W-1:0] st_r, st_nxt;
  logic [EW-1:0] res_r, res_nxt;
  logic resv_r, resv_nxt;
  logic ov_r, ov_nxt;
  logic [bhpq_pkg::STAT_W-1:0] o_st_r, o_st_nxt;
  logic signed [bhpq_pkg::KEY_W-1:0] o_key_r, o_key_nxt;
  logic [bhpq_pkg::TAG_W-1:0] o_tag_r, o_tag_nxt;
  logic o_tv_r, o_tv_nxt;
  logic [bhpq_pkg::COUNT_W-1:0] o_cnt_r, o_cnt_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic cfg_wr;
  logic [AW+1:0] lchild, rchild, cnt_x;
  logic [AW-1:0] parent;
  logic [CW:0] idx_inc;
  logic [CW-1:0] cnt_dec;
  logic signed [KEY_BITS-1:0] key_unb;
  logic [CW+bhpq_pkg::COUNT_W-1:0] cnt_wide;

  bhpq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic ranks_ahead(input logic [EW-1:0] a, input logic [EW-1:0] b,
                                       input logic omax);
    logic [KEY_BITS-1:0] ak, bk;
    logic [TAG_BITS-1:0] at, bt;
    ak = a[EW-1:TAG_BITS];
    bk = b[EW-1:TAG_BITS];
    at = a[TAG_BITS-1:0];
    bt = b[TAG_BITS-1:0];
    if (omax) begin
      ranks_ahead = (ak != bk) ? (ak > bk) : (at > bt);
    end else begin
      ranks_ahead = (ak != bk) ? (ak < bk) : (at < bt);
    end
  endfunction

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == bhpq_pkg::REG_ORDER_MAX)
                      ? bhpq_pkg::PDATA_W'(order_r) : '0;

  assign in_ch.ready = (state_r == S_IDLE) && !cfg_wr && !pend_r;
  assign out_ch.valid     = ov_r;
  assign out_ch.status    = o_st_r;
  assign out_ch.out_key   = o_key_r;
  assign out_ch.out_tag   = o_tag_r;
  assign out_ch.top_valid = o_tv_r;
  assign out_ch.count     = o_cnt_r;

  assign lchild  = {1'b0, pos_r, 1'b1};
  assign rchild  = lchild + (AW+2)'(1);
  assign cnt_x   = (AW+2)'(cnt_r);
  assign parent  = AW'((pos_r - AW'(1)) >> 1);
  assign idx_inc = (CW+1)'(idx_r) + (CW+1)'(1);
  assign cnt_dec = cnt_r - CW'(1);
  assign key_unb = res_r[EW-1:TAG_BITS] ^ KSIGN;
  assign cnt_wide = (CW+bhpq_pkg::COUNT_W)'(cnt_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    order_nxt = order_r;
    cmd_nxt   = cmd_r;
    kin_nxt   = kin_r;
    tin_nxt   = tin_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    base_nxt  = base_r;
    chi_nxt   = chi_r;
    mv_nxt    = mv_r;
    ch_nxt    = ch_r;
    ud_nxt    = ud_r;
    reb_nxt   = reb_r;
    have_nxt  = have_r;
    pend_nxt  = pend_r;
    st_nxt    = st_r;
    res_nxt   = res_r;
    resv_nxt  = resv_r;
    ov_nxt    = ov_r;
    o_st_nxt  = o_st_r;
    o_key_nxt = o_key_r;
    o_tag_nxt = o_tag_r;
    o_tv_nxt  = o_tv_r;
    o_cnt_nxt = o_cnt_r;
    we    = 1'b0;
    waddr = pos_r;
    wdata = mv_r;
    raddr = '0;

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    // finished result waits here until the output register frees up
    if (pend_r && (!ov_r || out_ch.ready)) begin
      pend_nxt  = 1'b0;
      ov_nxt    = 1'b1;
      o_st_nxt  = st_r;
      o_tv_nxt  = resv_r;
      o_key_nxt = resv_r ? bhpq_pkg::KEY_W'(key_unb) : '0;
      o_tag_nxt = resv_r ? bhpq_pkg::TAG_W'(res_r[TAG_BITS-1:0]) : '0;
      o_cnt_nxt = cnt_wide[bhpq_pkg::COUNT_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (cfg_wr) begin
          if (cfg_paddr[2] == bhpq_pkg::REG_ORDER_MAX && cfg_pwdata[0] != order_r) begin
            order_nxt = cfg_pwdata[0];
            if (cnt_r > CW'(1)) begin
              reb_nxt   = 1'b1;
              base_nxt  = AW'((cnt_r >> 1) - CW'(1));
              state_nxt = S_LA_RD;
            end
          end
        end else if (in_ch.valid && !pend_r) begin
          cmd_nxt  = in_ch.command;
          kin_nxt  = in_ch.key[KEY_BITS-1:0] ^ KSIGN;
          tin_nxt  = in_ch.tag[TAG_BITS-1:0];
          st_nxt   = bhpq_pkg::ST_OK;
          have_nxt = 1'b0;
          idx_nxt  = '0;
          case (in_ch.command)
            bhpq_pkg::CMD_INSERT: begin
              if (cnt_r == CW'(DEPTH)) begin
                st_nxt    = bhpq_pkg::ST_FULL;
                state_nxt = S_TOP;
              end else if (cnt_r == '0) begin
                mv_nxt    = {in_ch.key[KEY_BITS-1:0] ^ KSIGN, in_ch.tag[TAG_BITS-1:0]};
                pos_nxt   = '0;
                cnt_nxt   = CW'(1);
                ud_nxt    = 1'b0;
                state_nxt = S_UP_RD;
              end else begin
                state_nxt = S_SC_RD;
              end
            end
            bhpq_pkg::CMD_EXTRACT: begin
              if (cnt_r == '0) begin
                st_nxt    = bhpq_pkg::ST_EMPTY;
                state_nxt = S_TOP;
              end else begin
                state_nxt = S_EX_RD;
              end
            end
            bhpq_pkg::CMD_ERASE: begin
              if (cnt_r == '0) begin
                st_nxt    = bhpq_pkg::ST_EMPTY;
                state_nxt = S_TOP;
              end else begin
                state_nxt = S_SC_RD;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                st_nxt = bhpq_pkg::ST_EMPTY;
              end
              state_nxt = S_TOP;
            end
          endcase
        end
      end
      S_SC_RD: begin
        raddr     = idx_r;
        state_nxt = S_SC_CK;
      end
      S_SC_CK: begin
        if (rdata[TAG_BITS-1:0] == tin_r) begin
          if (cmd_r == bhpq_pkg::CMD_INSERT) begin
            st_nxt    = bhpq_pkg::ST_DUP;
            state_nxt = S_TOP;
          end else begin
            cnt_nxt = cnt_dec;
            if (CW'(idx_r) == cnt_dec) begin
              state_nxt = S_TOP;
            end else begin
              pos_nxt   = idx_r;
              ud_nxt    = 1'b1;
              state_nxt = S_LA_RD;
            end
          end
        end else if (idx_inc == (CW+1)'(cnt_r)) begin
          if (cmd_r == bhpq_pkg::CMD_INSERT) begin
            mv_nxt    = {kin_r, tin_r};
            pos_nxt   = AW'(cnt_r);
            cnt_nxt   = cnt_r + CW'(1);
            ud_nxt    = 1'b0;
            state_nxt = S_UP_RD;
          end else begin
            st_nxt    = bhpq_pkg::ST_NOTFOUND;
            state_nxt = S_TOP;
          end
        end else begin
          idx_nxt   = AW'(idx_inc);
          state_nxt = S_SC_RD;
        end
      end
      S_EX_RD: begin
        raddr     = '0;
        state_nxt = S_EX_CK;
      end
      S_EX_CK: begin
        res_nxt  = rdata;
        resv_nxt = 1'b1;
        have_nxt = 1'b1;
        cnt_nxt  = cnt_dec;
        pos_nxt  = '0;
        ud_nxt   = 1'b0;
        state_nxt = (cnt_dec == '0) ? S_TOP : S_LA_RD;
      end
      S_LA_RD: begin
        // last entry for extract and erase, next subtree root for a rebuild
        raddr     = reb_r ? base_r : AW'(cnt_r);
        state_nxt = S_LA_CK;
      end
      S_LA_CK: begin
        mv_nxt = rdata;
        if (reb_r) begin
          pos_nxt   = base_r;
          state_nxt = S_DL_RD;
        end else if (cmd_r == bhpq_pkg::CMD_EXTRACT) begin
          state_nxt = S_DL_RD;
        end else begin
          state_nxt = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          if (ud_r) begin
            state_nxt = S_DL_RD;
          end else begin
            we        = 1'b1;
            state_nxt = S_NEXT;
          end
        end else begin
          raddr     = parent;
          state_nxt = S_UP_CK;
        end
      end
      S_UP_CK: begin
        if (ranks_ahead(mv_r, rdata, order_r)) begin
          we        = 1'b1;
          wdata     = rdata;
          pos_nxt   = parent;
          ud_nxt    = 1'b0;
          state_nxt = S_UP_RD;
        end else if (ud_r) begin
          state_nxt = S_DL_RD;
        end else begin
          we        = 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_DL_RD: begin
        if (lchild >= cnt_x) begin
          we        = 1'b1;
          state_nxt = S_NEXT;
        end else begin
          raddr     = lchild[AW-1:0];
          state_nxt = S_DL_CK;
        end
      end
      S_DL_CK: begin
        ch_nxt    = rdata;
        chi_nxt   = lchild[AW-1:0];
        state_nxt = (rchild < cnt_x) ? S_DR_RD : S_DN_DEC;
      end
      S_DR_RD: begin
        raddr     = rchild[AW-1:0];
        state_nxt = S_DR_CK;
      end
      S_DR_CK: begin
        if (ranks_ahead(rdata, ch_r, order_r)) begin
          ch_nxt  = rdata;
          chi_nxt = rchild[AW-1:0];
        end
        state_nxt = S_DN_DEC;
      end
      S_DN_DEC: begin
        we = 1'b1;
        if (ranks_ahead(ch_r, mv_r, order_r)) begin
          wdata     = ch_r;
          pos_nxt   = chi_r;
          state_nxt = S_DL_RD;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (reb_r) begin
          if (base_r == '0) begin
            reb_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            base_nxt  = base_r - AW'(1);
            state_nxt = S_LA_RD;
          end
        end else begin
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        // have_r marks that the reported entry is already in res_r
        if (have_r || cnt_r == '0) begin
          resv_nxt  = have_r;
          pend_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          raddr     = '0;
          have_nxt  = 1'b1;
          state_nxt = S_EX_RD;
          cmd_nxt   = bhpq_pkg::CMD_PEEK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a peek-style top read lands back in S_EX_CK; keep count intact there
    if (state_r == S_EX_CK && cmd_r == bhpq_pkg::CMD_PEEK) begin
      res_nxt   = rdata;
      resv_nxt  = 1'b1;
      have_nxt  = 1'b1;
      cnt_nxt   = cnt_r;
      pend_nxt  = 1'b1;
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      order_r <= 1'b1;
      reb_r   <= 1'b0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      order_r <= order_nxt;
      reb_r   <= reb_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    kin_r   <= kin_nxt;
    tin_r   <= tin_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    base_r  <= base_nxt;
    chi_r   <= chi_nxt;
    mv_r    <= mv_nxt;
    ch_r    <= ch_nxt;
    ud_r    <= ud_nxt;
    have_r  <= have_nxt;
    st_r    <= st_nxt;
    res_r   <= res_nxt;
    resv_r  <= resv_nxt;
    o_st_r  <= o_st_nxt;
    o_key_r <= o_key_nxt;
    o_tag_r <= o_tag_nxt;
    o_tv_r  <= o_tv_nxt;
    o_cnt_r <= o_cnt_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("entry count above depth");
  a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r != S_IDLE)) else $error("heap write while idle");
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("request taken twice");
  a_reb_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    reb_r |-> !in_ch.ready) else $error("request taken during rebuild");
endmodule
`default_nettype wire

[test/bhpq_checker.sv]
`timescale 1ns / 1ps
module bhpq_checker (
  input  wire                          clk,
  input  wire                          rst_n,
  bhpq_in_if                           in_ch,
  bhpq_out_if                          out_ch,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire                          cfg_pready,
  input  wire [bhpq_pkg::PADDR_W-1:0]  cfg_paddr,
  input  wire [bhpq_pkg::PDATA_W-1:0]  cfg_pwdata,
  output int                           pending,
  output int                           fail_count
);
  localparam int SLOTS = bhpq_pkg::DEPTH_DEF;

  typedef struct packed {
    logic [bhpq_pkg::STAT_W-1:0]       status;
    logic signed [bhpq_pkg::KEY_W-1:0] key;
    logic [bhpq_pkg::TAG_W-1:0]        tag;
    logic                              top_valid;
    logic [bhpq_pkg::COUNT_W-1:0]      count;
  } reply_t;

  logic signed [bhpq_pkg::KEY_W-1:0] heap_key [SLOTS];
  logic [bhpq_pkg::TAG_W-1:0]        heap_tag [SLOTS];
  int                                held;
  bit                                serve_max;
  reply_t                            reply_q[$];

  assign pending = reply_q.size();

  function automatic bit outranks(int a, int b);
    if (heap_key[a] != heap_key[b])
      return serve_max ? (heap_key[a] > heap_key[b]) : (heap_key[a] < heap_key[b]);
    return serve_max ? (heap_tag[a] > heap_tag[b]) : (heap_tag[a] < heap_tag[b]);
  endfunction

  function automatic void swap_slot(int a, int b);
    logic signed [bhpq_pkg::KEY_W-1:0] k;
    logic [bhpq_pkg::TAG_W-1:0]        t;
    k = heap_key[a]; t = heap_tag[a];
    heap_key[a] = heap_key[b]; heap_tag[a] = heap_tag[b];
    heap_key[b] = k; heap_tag[b] = t;
  endfunction

  function automatic int sift_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!outranks(i, p)) break;
      swap_slot(i, p);
      i = p;
    end
    return i;
  endfunction

  function automatic void heapify_down(int i);
    int l, r, best;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      best = i;
      if (l < held && outranks(l, best)) best = l;
      if (r < held && outranks(r, best)) best = r;
      if (best == i) return;
      swap_slot(i, best);
      i = best;
    end
  endfunction

  function automatic int tag_slot(logic [bhpq_pkg::TAG_W-1:0] t);
    for (int i = 0; i < held; i++)
      if (heap_tag[i] == t) return i;
    return -1;
  endfunction

  function automatic reply_t apply_request(logic [bhpq_pkg::CMD_W-1:0] cmd,
                                           logic signed [bhpq_pkg::KEY_W-1:0] k,
                                           logic [bhpq_pkg::TAG_W-1:0] t);
    reply_t r;
    int     pos;
    bit     taken;
    r = '0;
    r.status = bhpq_pkg::ST_OK;
    taken = 0;
    case (cmd)
      bhpq_pkg::CMD_INSERT: begin
        if (held >= SLOTS) r.status = bhpq_pkg::ST_FULL;
        else if (tag_slot(t) >= 0) r.status = bhpq_pkg::ST_DUP;
        else begin
          heap_key[held] = k;
          heap_tag[held] = t;
          held++;
          void'(sift_up(held - 1));
        end
      end
      bhpq_pkg::CMD_EXTRACT: begin
        if (held == 0) r.status = bhpq_pkg::ST_EMPTY;
        else begin
          r.key = heap_key[0];
          r.tag = heap_tag[0];
          r.top_valid = 1'b1;
          taken = 1;
          held--;
          heap_key[0] = heap_key[held];
          heap_tag[0] = heap_tag[held];
          heapify_down(0);
        end
      end
      bhpq_pkg::CMD_ERASE: begin
        pos = tag_slot(t);
        if (held == 0) r.status = bhpq_pkg::ST_EMPTY;
        else if (pos < 0) r.status = bhpq_pkg::ST_NOTFOUND;
        else begin
          held--;
          if (pos != held) begin
            heap_key[pos] = heap_key[held];
            heap_tag[pos] = heap_tag[held];
            if (sift_up(pos) == pos) heapify_down(pos);
          end
        end
      end
      default: if (held == 0) r.status = bhpq_pkg::ST_EMPTY;
    endcase
    if (!taken && held > 0) begin
      r.key = heap_key[0];
      r.tag = heap_tag[0];
      r.top_valid = 1'b1;
    end
    r.count = held[bhpq_pkg::COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want, got;
    if (!rst_n) begin
      held = 0;
      serve_max = 1'b1;
      fail_count <= 0;
      reply_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          (cfg_paddr >> 2) == bhpq_pkg::REG_ORDER_MAX && cfg_pwdata[0] != serve_max) begin
        serve_max = cfg_pwdata[0];
        for (int i = held / 2 - 1; i >= 0; i--) heapify_down(i);
      end
      if (in_ch.valid && in_ch.ready)
        reply_q = {reply_q, apply_request(in_ch.command, in_ch.key, in_ch.tag)};
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.out_key, out_ch.out_tag, out_ch.top_valid,
                out_ch.count};
        if (reply_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected reply %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = reply_q.pop_front();
          if (want !== got) begin
            if (fail_count < 10) $display("reply mismatch: expected %p got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
  logic                          clk;
  logic                          rst_n;
  logic                          psel, penable, pwrite;
  logic [bhpq_pkg::PADDR_W-1:0]  paddr;
  logic [bhpq_pkg::PDATA_W-1:0]  pwdata;
  logic [bhpq_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;
  int                            pending, fail_count;
  int                            idle_pct, stall_pct;
  longint                        cycles;

  bhpq_in_if  in_ch ();
  bhpq_out_if out_ch ();

  binary_heap_priority_queue u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(psel), .cfg_penable(penable), .cfg_pwrite(pwrite),
    .cfg_paddr(paddr), .cfg_pwdata(pwdata), .cfg_prdata(prdata),
    .cfg_pready(pready)
  );

  bhpq_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(psel), .cfg_penable(penable), .cfg_pwrite(pwrite),
    .cfg_pready(pready), .cfg_paddr(paddr), .cfg_pwdata(pwdata),
    .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_ch.valid = 0; in_ch.command = bhpq_pkg::CMD_PEEK; in_ch.key = '0; in_ch.tag = '0;
    out_ch.ready = 0;
    idle_pct = 0; stall_pct = 0;
  end

  always @(posedge clk) begin
    cycles <= rst_n ? cycles + 1 : 0;
    if (cycles > 64'd20000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk)
    out_ch.ready <= ($urandom_range(99) >= stall_pct);

  task automatic send(logic [bhpq_pkg::CMD_W-1:0] cmd,
                      logic signed [bhpq_pkg::KEY_W-1:0] k,
                      logic [bhpq_pkg::TAG_W-1:0] t);
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.key <= k;
    in_ch.tag <= t;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // wait for all replies and for the block to be idle (a rebuild may still run)
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || !in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [bhpq_pkg::PADDR_W-1:0] a,
                           logic [bhpq_pkg::PDATA_W-1:0] d);
    drain();
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [bhpq_pkg::KEY_W-1:0] rand_key();
    if ($urandom_range(1)) return bhpq_pkg::KEY_W'({$urandom, $urandom});
    return bhpq_pkg::KEY_W'($signed($urandom_range(6)) - 3);
  endfunction

  function automatic logic [bhpq_pkg::TAG_W-1:0] rand_tag();
    if ($urandom_range(9) == 0) return bhpq_pkg::TAG_W'($urandom);
    return bhpq_pkg::TAG_W'($urandom_range(63));
  endfunction

  task automatic random_requests(int n);
    int c;
    logic [bhpq_pkg::CMD_W-1:0] cmd;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(99);
      cmd = c < 45 ? bhpq_pkg::CMD_INSERT : c < 70 ? bhpq_pkg::CMD_EXTRACT :
            c < 90 ? bhpq_pkg::CMD_ERASE : bhpq_pkg::CMD_PEEK;
      send(cmd, rand_key(), rand_tag());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // empty queue cases
    send(bhpq_pkg::CMD_EXTRACT, '0, '0);
    send(bhpq_pkg::CMD_PEEK, '0, '0);
    send(bhpq_pkg::CMD_ERASE, '0, 16'h0001);
    // key and tag extremes, ties on key
    send(bhpq_pkg::CMD_INSERT, {1'b0, {(bhpq_pkg::KEY_W-1){1'b1}}}, 16'hffff);
    send(bhpq_pkg::CMD_INSERT, {1'b1, {(bhpq_pkg::KEY_W-1){1'b0}}}, 16'h0000);
    send(bhpq_pkg::CMD_INSERT, 48'sd5, 16'h0010);
    send(bhpq_pkg::CMD_INSERT, 48'sd5, 16'h0011);
    send(bhpq_pkg::CMD_INSERT, -48'sd1, 16'h0012);
    send(bhpq_pkg::CMD_INSERT, 48'sd7, 16'hffff);
    send(bhpq_pkg::CMD_PEEK, '0, '0);
    send(bhpq_pkg::CMD_ERASE, '0, 16'h1234);
    send(bhpq_pkg::CMD_ERASE, '0, 16'h0010);
    send(bhpq_pkg::CMD_EXTRACT, '0, '0);
    write_reg(3'd0, 32'h0);
    send(bhpq_pkg::CMD_EXTRACT, '0, '0);
    send(bhpq_pkg::CMD_INSERT, 48'sd5, 16'h0020);
    send(bhpq_pkg::CMD_EXTRACT, '0, '0);
    write_reg(3'd0, 32'h0);
    write_reg(3'd4, 32'hffffffff);
    send(bhpq_pkg::CMD_PEEK, '0, '0);
    write_reg(3'd0, 32'h1);
    for (int i = 0; i < 4; i++) send(bhpq_pkg::CMD_EXTRACT, '0, '0);

    // fill the queue completely
    for (int i = 0; i < bhpq_pkg::DEPTH_DEF; i++)
      send(bhpq_pkg::CMD_INSERT, rand_key(), bhpq_pkg::TAG_W'(i));
    send(bhpq_pkg::CMD_INSERT, 48'sd1, 16'h0003);
    send(bhpq_pkg::CMD_INSERT, 48'sd1, 16'h9000);
    write_reg(3'd0, 32'h0);
    send(bhpq_pkg::CMD_ERASE, '0, 16'd1023);
    send(bhpq_pkg::CMD_ERASE, '0, 16'd0);
    for (int i = 0; i < 20; i++)
      send(bhpq_pkg::CMD_ERASE, '0, bhpq_pkg::TAG_W'($urandom_range(1023)));
    write_reg(3'd0, 32'h1);
    for (int i = 0; i < 400; i++) send(bhpq_pkg::CMD_EXTRACT, '0, '0);

    random_requests(110);
    write_reg(3'd0, 32'h0);
    idle_pct = 80; stall_pct = 0;
    random_requests(110);
    write_reg(3'd0, 32'h1);
    idle_pct = 0; stall_pct = 80;
    random_requests(110);
    write_reg(3'd0, 32'h0);
    idle_pct = 29; stall_pct = 29;
    random_requests(110);

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[filelist.f]
src/bhpq_pkg.sv
src/bhpq_in_if.sv
src/bhpq_out_if.sv
src/bhpq_ram.sv
src/binary_heap_priority_queue.sv
test/bhpq_checker.sv
test/tb.sv
